// File: src/frustum_sphere_culler_top_defines.svh
// ----------------------------------------------------------------------------
// frustum_sphere_culler_top_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_SPHERE_CULLER_TOP_DEFINES_SVH
`define FRUSTUM_SPHERE_CULLER_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define FSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fsc assertion failed");

// next-cycle implication, masked during reset
`define FSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fsc assertion failed");

// next-cycle implication, always active
`define FSC_ASSERT_NEXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fsc assertion failed");

`endif

// File: src/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Types, constants and helpers for the frustum sphere culler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsc_pkg;

    localparam int VAL_W   = 32;
    localparam int ACC_W   = 66;
    localparam int PLANES  = 6;
    localparam int MAT_N   = 16;
    localparam int PSTORE  = PLANES * 4;
    localparam int DIVD_W  = 48;
    localparam int IN_DW   = 168;
    localparam int OUT_DW  = 8;

    localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sh0001_0000;

    localparam logic [1:0] CMD_LOAD_PROJ = 2'd0;
    localparam logic [1:0] CMD_LOAD_VIEW = 2'd1;
    localparam logic [1:0] CMD_BUILD     = 2'd2;
    localparam logic [1:0] CMD_TEST      = 2'd3;

    typedef struct packed {
        logic                    valid;
        logic                    clr;
        logic                    last;
        logic                    noshift;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
    } t_mac_op;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > $signed(66'sh0_7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -$signed(66'sh0_8000_0000)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    // right, left, bottom, top, back, front
    function automatic logic plane_neg(input logic [2:0] p);
        logic r;
        case (p)
            3'd0, 3'd3, 3'd4: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/fsc_mac.sv
// ----------------------------------------------------------------------------
// fsc_mac
// Shared two-stage multiply-accumulate: registered product, then accumulate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsc_mac import fsc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_mac_op                 i_op,
    output logic signed [ACC_W-1:0]      o_acc,
    output logic                         o_done
);

    logic signed [2*VAL_W-1:0] r_prod;
    logic                      r_v, r_clr, r_last, r_ns;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   ext;
    logic                      r_done;

    always_comb begin
        // floor shift by the fraction width unless the full product is wanted
        ext   = r_ns ? {{2{r_prod[63]}}, r_prod} : {{18{r_prod[63]}}, r_prod[63:16]};
        n_acc = (r_clr ? '0 : r_acc) + ext;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_op.a * i_op.b;
        r_clr  <= i_op.clr;
        r_last <= i_op.last;
        r_ns   <= i_op.noshift;
        if (r_v) begin
            r_acc <= n_acc;
        end
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v    <= i_op.valid;
            r_done <= r_v && r_last;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: src/fsc_sqrt.sv
// ----------------------------------------------------------------------------
// fsc_sqrt
// Bit-serial integer square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsc_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_value,
    output logic [31:0]      o_root,
    output logic             o_done
);

    logic [63:0] r_x;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [34:0] rem_sh, trial;
    logic        take;

    always_comb begin
        rem_sh = {r_rem[32:0], r_x[63:62]};
        trial  = {1'b0, r_root, 2'b01};
        take   = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[61:0], 2'b00};
            r_rem  <= take ? rem_sh - trial : rem_sh;
            r_root <= {r_root[30:0], take};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: src/fsc_div.sv
// ----------------------------------------------------------------------------
// fsc_div
// Restoring unsigned divider, 48-bit dividend by 32-bit divisor, bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsc_div import fsc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [31:0]       i_divisor,
    output logic [DIVD_W-1:0]      o_quot,
    output logic                   o_done
);

    logic [DIVD_W-1:0] r_q;
    logic [31:0]       r_r;
    logic [31:0]       r_d;
    logic [5:0]        r_cnt;
    logic              r_busy, r_done;
    logic [32:0]       rr;
    logic              take;

    always_comb begin
        rr   = {r_r, r_q[DIVD_W-1]};
        take = rr >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DIVD_W-2:0], take};
            r_r <= take ? 32'(rr - {1'b0, r_d}) : rr[31:0];
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'(DIVD_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: src/frustum_sphere_culler_top.sv
// Load request: written into its matrix when taken, no answer.
// Test request: 24 MAC issues, answer valid once the sixth plane's dot product is done.
// Build request: the clip matrix product, then per plane the terms and squares, a
//   square root and 4 divides (raw terms are written instead of the divides for a
//   zero-length plane).
// One request at a time, the next taken the cycle after the answer leaves; synchronous
//   active-low reset clears control; planes read as zero until built.
// ----------------------------------------------------------------------------
// frustum_sphere_culler_top
// Frustum plane extraction and sphere culling, Q16.16, on one shared MAC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frustum_sphere_culler_top import fsc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // elem_index, elem_value, pos_x, pos_y, pos_z, radius, zero pad
    input  wire logic [IN_DW-1:0]  s_axis_tdata,
    // cmd
    input  wire logic [1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // inside_res, degenerate, zero pad
    output logic [OUT_DW-1:0]      m_axis_tdata,
    // answer_kind
    output logic [0:0]             m_axis_tuser
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLIP = 4'd1;
    localparam logic [3:0] S_TERM = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_RAW  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_TEST = 4'd7;

    logic [3:0] r_state;
    logic [6:0] r_icnt;
    logic [3:0] r_dcnt;
    logic [2:0] r_plane;
    logic [1:0] r_j;
    logic       r_wait, r_deg, r_outside;
    logic       r_ovalid, r_okind, r_oinside, r_odeg;

    logic signed [VAL_W-1:0] r_proj [MAT_N];
    logic signed [VAL_W-1:0] r_view [MAT_N];
    logic signed [VAL_W-1:0] r_clip [MAT_N];
    logic signed [VAL_W-1:0] r_t    [4];
    logic signed [VAL_W-1:0] r_pmem [PSTORE];
    logic [PLANES-1:0]       r_pvalid;
    logic signed [VAL_W-1:0] r_x, r_y, r_z;
    logic [30:0]             r_rad;
    logic [31:0]             r_mag;

    logic [3:0]              in_idx;
    logic signed [VAL_W-1:0] in_val;
    logic                    accept;

    t_mac_op                 mac_op;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_done;

    logic [3:0]              clip_addr;
    logic signed [VAL_W-1:0] clip_rd;
    logic [1:0]              t_idx;
    logic signed [VAL_W-1:0] t_rd;
    logic signed [VAL_W-1:0] plane_rd;
    logic [4:0]              prd_addr;
    logic [4:0]              pwr_addr;

    logic                    sqrt_start, sqrt_done;
    logic [31:0]             sqrt_root;
    logic                    div_start, div_done;
    logic [DIVD_W-1:0]       div_quot;
    logic [31:0]             t_abs;
    logic signed [VAL_W-1:0] div_res;
    logic                    dot_out;

    assign in_idx = s_axis_tdata[3:0];
    assign in_val = s_axis_tdata[35:4];
    assign accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_odeg, r_oinside};
    assign m_axis_tuser  = r_okind;

    assign t_idx    = (r_state == S_SQ) ? r_icnt[1:0] : r_j;
    assign t_rd     = r_t[t_idx];
    assign clip_rd  = r_clip[clip_addr];
    assign prd_addr = (r_icnt[4:0] < 5'(PSTORE)) ? r_icnt[4:0] : '0;
    assign plane_rd = r_pvalid[prd_addr[4:2]] ? r_pmem[prd_addr] : '0;
    assign pwr_addr = {r_plane, r_j};

    assign t_abs   = t_rd[31] ? ~t_rd + 32'd1 : t_rd;
    assign dot_out = mac_acc <= -$signed({35'd0, r_rad});

    always_comb begin
        if (t_rd[31]) begin
            div_res = (div_quot > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                      : -$signed(div_quot[31:0]);
        end else begin
            div_res = (div_quot > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                      : $signed(div_quot[31:0]);
        end
    end

    always_comb begin
        mac_op    = '0;
        clip_addr = {r_icnt[2:1], 2'd3};
        unique case (r_state)
            S_CLIP: begin
                if (r_icnt < 7'd64) begin
                    mac_op.valid = 1'b1;
                    mac_op.a     = r_view[{r_icnt[5:4], r_icnt[1:0]}];
                    mac_op.b     = r_proj[{r_icnt[1:0], r_icnt[3:2]}];
                    mac_op.clr   = r_icnt[1:0] == 2'd0;
                    mac_op.last  = r_icnt[1:0] == 2'd3;
                end
            end
            S_TERM: begin
                if (r_icnt[0]) begin
                    clip_addr = {r_icnt[2:1], r_plane[2:1]};
                end
                if (r_icnt < 7'd8) begin
                    mac_op.valid = 1'b1;
                    mac_op.a     = clip_rd;
                    mac_op.b     = (r_icnt[0] && plane_neg(r_plane)) ? -ONE_Q16 : ONE_Q16;
                    mac_op.clr   = !r_icnt[0];
                    mac_op.last  = r_icnt[0];
                end
            end
            S_SQ: begin
                if (r_icnt < 7'd3) begin
                    mac_op.valid   = 1'b1;
                    mac_op.a       = t_rd;
                    mac_op.b       = t_rd;
                    mac_op.noshift = 1'b1;
                    mac_op.clr     = r_icnt == 7'd0;
                    mac_op.last    = r_icnt == 7'd2;
                end
            end
            S_TEST: begin
                if (r_icnt < 7'(PSTORE)) begin
                    mac_op.valid = 1'b1;
                    mac_op.a     = plane_rd;
                    case (r_icnt[1:0])
                        2'd0:    mac_op.b = r_x;
                        2'd1:    mac_op.b = r_y;
                        2'd2:    mac_op.b = r_z;
                        default: mac_op.b = ONE_Q16;
                    endcase
                    mac_op.clr  = r_icnt[1:0] == 2'd0;
                    mac_op.last = r_icnt[1:0] == 2'd3;
                end
            end
            default: begin
            end
        endcase
    end

    assign sqrt_start = (r_state == S_SQ) && mac_done;
    assign div_start  = (r_state == S_DIV) && !r_wait;

    fsc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    fsc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (mac_acc[63:0]),
        .o_root  (sqrt_root),
        .o_done  (sqrt_done)
    );

    fsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({t_abs, 16'd0}),
        .i_divisor  (r_mag),
        .o_quot     (div_quot),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            unique case (s_axis_tuser)
                CMD_LOAD_PROJ: r_proj[in_idx] <= in_val;
                CMD_LOAD_VIEW: r_view[in_idx] <= in_val;
                CMD_BUILD:     begin end
                CMD_TEST: begin
                    r_x   <= s_axis_tdata[67:36];
                    r_y   <= s_axis_tdata[99:68];
                    r_z   <= s_axis_tdata[131:100];
                    r_rad <= s_axis_tdata[162:132];
                end
                default: begin end
            endcase
        end
        if ((r_state == S_CLIP) && mac_done) begin
            r_clip[r_dcnt] <= sat32(mac_acc);
        end
        if ((r_state == S_TERM) && mac_done) begin
            r_t[r_dcnt[1:0]] <= sat32(mac_acc);
        end
        if ((r_state == S_SQRT) && sqrt_done) begin
            r_mag <= sqrt_root;
        end
        if (r_state == S_RAW) begin
            r_pmem[pwr_addr] <= t_rd;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_pmem[pwr_addr] <= div_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_icnt    <= '0;
            r_dcnt    <= '0;
            r_plane   <= '0;
            r_j       <= '0;
            r_wait    <= 1'b0;
            r_deg     <= 1'b0;
            r_outside <= 1'b0;
            r_pvalid  <= '0;
            r_ovalid  <= 1'b0;
            r_okind   <= 1'b0;
            r_oinside <= 1'b0;
            r_odeg    <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (mac_op.valid) begin
                r_icnt <= r_icnt + 7'd1;
            end
            unique case (r_state) inside
                S_IDLE: begin
                    r_icnt <= '0;
                    r_dcnt <= '0;
                    if (accept && (s_axis_tuser == CMD_BUILD)) begin
                        r_state <= S_CLIP;
                        r_deg   <= 1'b0;
                    end else if (accept && (s_axis_tuser == CMD_TEST)) begin
                        r_state   <= S_TEST;
                        r_outside <= 1'b0;
                    end
                end
                S_CLIP: begin
                    if (mac_done) begin
                        r_dcnt <= r_dcnt + 4'd1;
                        if (r_dcnt == 4'd15) begin
                            r_state <= S_TERM;
                            r_icnt  <= '0;
                            r_dcnt  <= '0;
                            r_plane <= '0;
                        end
                    end
                end
                S_TERM: begin
                    if (mac_done) begin
                        r_dcnt <= r_dcnt + 4'd1;
                        if (r_dcnt == 4'd3) begin
                            r_state <= S_SQ;
                            r_icnt  <= '0;
                            r_dcnt  <= '0;
                        end
                    end
                end
                S_SQ: begin
                    if (mac_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_j    <= '0;
                        r_wait <= 1'b0;
                        if (sqrt_root == 32'd0) begin
                            r_deg   <= 1'b1;
                            r_state <= S_RAW;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_RAW, S_DIV: begin
                    if (div_start) begin
                        r_wait <= 1'b1;
                    end
                    if ((r_state == S_RAW) || div_done) begin
                        r_wait              <= 1'b0;
                        r_j                 <= r_j + 2'd1;
                        r_pvalid[r_plane]   <= 1'b1;
                        if (r_j == 2'd3) begin
                            r_icnt <= '0;
                            r_dcnt <= '0;
                            if (r_plane == 3'(PLANES - 1)) begin
                                r_state   <= S_IDLE;
                                r_ovalid  <= 1'b1;
                                r_okind   <= 1'b0;
                                r_oinside <= 1'b0;
                                r_odeg    <= r_deg;
                            end else begin
                                r_plane <= r_plane + 3'd1;
                                r_state <= S_TERM;
                            end
                        end
                    end
                end
                S_TEST: begin
                    if (mac_done) begin
                        r_dcnt <= r_dcnt + 4'd1;
                        if (dot_out) begin
                            r_outside <= 1'b1;
                        end
                        if (r_dcnt == 4'(PLANES - 1)) begin
                            r_state   <= S_IDLE;
                            r_ovalid  <= 1'b1;
                            r_okind   <= 1'b1;
                            r_oinside <= !(r_outside || dot_out);
                            r_odeg    <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/fsc_checker.sv
// ----------------------------------------------------------------------------
// fsc_checker
// Port-level checks for the frustum sphere culler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "frustum_sphere_culler_top_defines.svh"

module fsc_checker import fsc_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic [IN_DW-1:0]  s_axis_tdata,
    input wire logic [1:0]        s_axis_tuser,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [OUT_DW-1:0] m_axis_tdata,
    input wire logic [0:0]        m_axis_tuser
);

    // a new request is never taken while an answer waits
    `FSC_ASSERT_IMPL(a_no_accept_pending, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)

    // build answers carry no inside flag, test answers no degenerate flag
    `FSC_ASSERT_IMPL(a_field_use, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tuser[0] ? !m_axis_tdata[1] : !m_axis_tdata[0]) && (m_axis_tdata[7:2] == 6'd0))

    // a load gives no answer in the next cycle
    `FSC_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD_PROJ || s_axis_tuser == CMD_LOAD_VIEW), !m_axis_tvalid)

    `FSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `FSC_ASSERT_NEXT_ALL(a_reset_clears, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind frustum_sphere_culler_top fsc_checker u_fsc_checker (.*);

`default_nettype wire

// File: verif/tb_frustum_sphere_culler_top.sv
// ----------------------------------------------------------------------------
// tb_frustum_sphere_culler_top
// Self-checking bench: loads matrices, builds frustum planes and tests spheres
// and points against a cycle-free predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frustum_sphere_culler_top;
    import fsc_pkg::*;

    localparam int CYCLE_LIMIT = 16000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic kind;
        logic in_res;
        logic degen;
    } t_answer;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic [0:0]        m_axis_tuser;

    logic signed [31:0] proj_m [16];
    logic signed [31:0] view_m [16];
    logic signed [31:0] plane_m [24];
    t_answer            answer_q [$];
    int                 errors = 0;
    int                 req_count = 0;
    int                 cycles = 0;
    bit                 no_idle = 0;
    bit                 hold_req = 0;
    int                 hold_cnt = 0;

    frustum_sphere_culler_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] x, res, b;
        x = v;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic plane_build();
        longint      clip [16];
        longint      acc, base, oth;
        longint      t [4];
        logic [63:0] sq, mag;
        logic        degen;
        bit          neg;
        int          col;
        degen = 0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += (longint'(view_m[4*r+k]) * longint'(proj_m[4*k+c])) >>> 16;
                clip[4*r+c] = longint'(clamp32(acc));
            end
        end
        for (int p = 0; p < 6; p++) begin
            col = p / 2;
            neg = (p == 0) || (p == 3) || (p == 4);
            sq = 0;
            for (int j = 0; j < 4; j++) begin
                base = clip[4*j+3];
                oth = clip[4*j+col];
                t[j] = longint'(clamp32(neg ? base - oth : base + oth));
            end
            for (int j = 0; j < 3; j++) sq += 64'(t[j] * t[j]);
            mag = int_sqrt(sq);
            for (int j = 0; j < 4; j++) begin
                if (mag == 0) plane_m[4*p+j] = t[j][31:0];
                else plane_m[4*p+j] = clamp32((t[j] * 65536) / longint'(mag));
            end
            if (mag == 0) degen = 1;
        end
        return degen;
    endfunction

    function automatic logic sphere_inside(input logic signed [31:0] x, y, z,
                                           input logic [30:0] rad);
        longint dot;
        for (int p = 0; p < 6; p++) begin
            dot = ((longint'(plane_m[4*p]) * longint'(x)) >>> 16)
                + ((longint'(plane_m[4*p+1]) * longint'(y)) >>> 16)
                + ((longint'(plane_m[4*p+2]) * longint'(z)) >>> 16)
                + longint'(plane_m[4*p+3]);
            if (dot <= -longint'({1'b0, rad})) return 0;
        end
        return 1;
    endfunction

    task automatic send_req(input logic [1:0] cmd, input logic [3:0] idx,
                            input logic signed [31:0] val, x, y, z,
                            input logic [30:0] rad);
        t_answer ans;
        if (!no_idle && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'd0, rad, z, y, x, val, idx};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        req_count++;
        case (cmd)
            CMD_LOAD_PROJ: proj_m[idx] = val;
            CMD_LOAD_VIEW: view_m[idx] = val;
            CMD_BUILD: begin
                ans.kind = 0; ans.in_res = 0; ans.degen = plane_build();
                answer_q.push_back(ans);
            end
            default: begin
                ans.kind = 1; ans.in_res = sphere_inside(x, y, z, rad); ans.degen = 0;
                answer_q.push_back(ans);
            end
        endcase
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        idle_input();
        while (answer_q.size() != 0) @(posedge i_clk);
    endtask

    // 0 full range, 1 small around zero, 2 extremes, 3 near identity
    function automatic logic signed [31:0] rand_val(input int mode, input bit diag);
        logic signed [31:0] v;
        case (mode)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sd0;
                    default: v = $urandom;
                endcase
            end
            default: v = (diag ? ONE_Q16 : 32'sd0)
                         + $signed($urandom_range(0, 32'h0000_8000)) - 32'sh0000_4000;
        endcase
        return v;
    endfunction

    task automatic load_matrix(input logic [1:0] cmd, input int mode);
        int order [16];
        for (int i = 0; i < 16; i++) order[i] = i;
        order.shuffle();
        for (int i = 0; i < 16; i++)
            send_req(cmd, order[i][3:0], rand_val(mode, order[i] % 5 == 0),
                     $urandom, $urandom, $urandom, 31'($urandom));
    endtask

    task automatic send_test(input bit wide);
        logic signed [31:0] x, y, z;
        logic [30:0]        rad;
        if (wide) begin
            x = $urandom; y = $urandom; z = $urandom;
        end else begin
            x = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            y = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            z = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        end
        case ($urandom_range(0, 3))
            0: rad = 31'd0;
            1: rad = 31'($urandom_range(0, 32'h0002_0000));
            2: rad = 31'($urandom);
            default: rad = 31'h7FFF_FFFF;
        endcase
        send_req(CMD_TEST, 4'($urandom), $urandom, x, y, z, rad);
    endtask

    task automatic test_reset_planes();
        send_req(CMD_TEST, 4'hF, 32'sh8000_0000, 32'sd0, 32'sd0, 32'sd0, 31'd0);
        send_req(CMD_TEST, 4'h0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        send_req(CMD_TEST, 4'h5, 32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 31'd1);
        drain();
    endtask

    task automatic test_degenerate_build();
        for (int i = 0; i < 16; i++)
            send_req(CMD_LOAD_PROJ, 4'(i), 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0);
        for (int i = 0; i < 16; i++)
            send_req(CMD_LOAD_VIEW, 4'(i), 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0);
        send_req(CMD_BUILD, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0);
        send_req(CMD_TEST, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0);
        send_req(CMD_TEST, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd5);
        drain();
    endtask

    task automatic test_identity_frustum();
        for (int i = 0; i < 16; i++) begin
            send_req(CMD_LOAD_PROJ, 4'(i), (i % 5 == 0) ? ONE_Q16 : 32'sd0,
                     32'sd0, 32'sd0, 32'sd0, 31'd0);
            send_req(CMD_LOAD_VIEW, 4'(i), (i % 5 == 0) ? ONE_Q16 : 32'sd0,
                     32'sd0, 32'sd0, 32'sd0, 31'd0);
        end
        send_req(CMD_BUILD, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0);
        send_req(CMD_TEST, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0);
        send_req(CMD_TEST, 4'd0, 32'sd0, 32'sh0002_0000, 32'sd0, 32'sd0, 31'd0);
        send_req(CMD_TEST, 4'd0, 32'sd0, 32'sh0002_0000, 32'sd0, 32'sd0, 31'h0002_0000);
        send_req(CMD_TEST, 4'd0, 32'sd0, 32'sd0, 32'sh8000_0000, 32'sd0, 31'h7FFF_FFFF);
        drain();
    endtask

    task automatic test_saturating_build();
        load_matrix(CMD_LOAD_PROJ, 2);
        load_matrix(CMD_LOAD_VIEW, 2);
        send_req(CMD_BUILD, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0);
        send_test(1);
        send_test(0);
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        for (int i = 0; i < 8; i++) send_test(0);
        send_req(CMD_BUILD, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0);
        send_test(1);
        drain();
    endtask

    task automatic test_random_frames();
        int mode;
        while (req_count < 1950) begin
            no_idle = ($urandom_range(0, 9) == 0);
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 3) != 0) load_matrix(CMD_LOAD_PROJ, mode);
            if ($urandom_range(0, 3) != 0) load_matrix(CMD_LOAD_VIEW, mode);
            repeat ($urandom_range(0, 3))
                send_req(($urandom_range(0, 1) != 0) ? CMD_LOAD_VIEW : CMD_LOAD_PROJ,
                         4'($urandom), rand_val(mode, 1'b0),
                         $urandom, $urandom, $urandom, 31'($urandom));
            send_req(CMD_BUILD, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
                     31'($urandom));
            repeat ($urandom_range(8, 20)) send_test($urandom_range(0, 4) == 0);
        end
        no_idle = 0;
        drain();
    endtask

    always @(posedge i_clk) begin
        t_answer ans;
        if (hold_req && hold_cnt == 0) begin
            hold_req = 0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 33);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d tdata=%h", $time,
                         m_axis_tuser[0], m_axis_tdata);
                errors++;
            end else begin
                ans = answer_q.pop_front();
                if (m_axis_tuser[0] !== ans.kind) begin
                    $display("%0t: answer_kind expected %0d actual %0d", $time,
                             ans.kind, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata[0] !== ans.in_res) begin
                    $display("%0t: inside_res expected %0d actual %0d", $time,
                             ans.in_res, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[1] !== ans.degen) begin
                    $display("%0t: degenerate expected %0d actual %0d", $time,
                             ans.degen, m_axis_tdata[1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 16; i++) begin
            proj_m[i] = 0;
            view_m[i] = 0;
        end
        for (int i = 0; i < 24; i++) plane_m[i] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_planes();
        test_degenerate_build();
        test_identity_frustum();
        test_saturating_build();
        test_backpressure();
        test_random_frames();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
